// ===== rtl/mlx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlx_pkg
// Shared types, constants and the ladder op sequence for the XZ ladder unit.
// ----------------------------------------------------------------------------
package mlx_pkg;

    localparam int SCALAR_BITS = 64;
    localparam int POS_W       = $clog2(SCALAR_BITS);
    localparam int WORD_W      = 64;
    localparam int RES_W       = 2 * WORD_W;
    localparam int DIG_W       = 4;
    localparam int NDIG        = WORD_W / DIG_W;
    localparam int CNT_W       = $clog2(NDIG);
    localparam int PADDR_W     = 6;
    localparam int RF_DEPTH    = 16;
    localparam int RF_AW       = $clog2(RF_DEPTH);
    localparam int PC_W        = 5;

    // configuration register indexes
    localparam logic [2:0] REG_MOD_LO = 3'd0;
    localparam logic [2:0] REG_MOD_HI = 3'd1;
    localparam logic [2:0] REG_NINV   = 3'd2;
    localparam logic [2:0] REG_A24_LO = 3'd3;
    localparam logic [2:0] REG_A24_HI = 3'd4;

    // register file slots
    localparam logic [RF_AW-1:0] P_PX  = RF_AW'(0);
    localparam logic [RF_AW-1:0] P_PZ  = RF_AW'(1);
    localparam logic [RF_AW-1:0] P_X1  = RF_AW'(2);
    localparam logic [RF_AW-1:0] P_Z1  = RF_AW'(3);
    localparam logic [RF_AW-1:0] P_X2  = RF_AW'(4);
    localparam logic [RF_AW-1:0] P_Z2  = RF_AW'(5);
    localparam logic [RF_AW-1:0] P_A24 = RF_AW'(6);
    localparam logic [RF_AW-1:0] P_U   = RF_AW'(7);
    localparam logic [RF_AW-1:0] P_V   = RF_AW'(8);
    localparam logic [RF_AW-1:0] P_W   = RF_AW'(9);

    // start of the doubling part and last op of one ladder step
    localparam logic [PC_W-1:0] PC_DBL  = PC_W'(12);
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(20);

    typedef struct packed {
        logic [WORD_W-1:0] point_x_low;
        logic [WORD_W-1:0] point_x_high;
        logic [WORD_W-1:0] point_z_low;
        logic [WORD_W-1:0] point_z_high;
        logic [WORD_W-1:0] scalar;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_x_low;
        logic [WORD_W-1:0] result_x_high;
        logic [WORD_W-1:0] result_z_low;
        logic [WORD_W-1:0] result_z_high;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_OP_RD,
        ST_OP_LAT,
        ST_ADDSUB,
        ST_MUL_LD,
        ST_MUL_RUN,
        ST_MUL_ACC,
        ST_FIX,
        ST_NEXT,
        ST_OUT_RD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } opcode_t;

    // logical operands, resolved against the scalar bit at run time
    typedef enum logic [3:0] {
        L_PX, L_PZ, L_A24, L_U, L_V, L_W,
        L_AX, L_AZ, L_BX, L_BZ,
        L_DX, L_DZ, L_DOX, L_DOZ,
        L_SX, L_SZ
    } lreg_t;

    typedef struct packed {
        opcode_t op;
        lreg_t   dst;
        lreg_t   srca;
        lreg_t   srcb;
    } uop_t;

    // one ladder step: differential add, then doubling
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        begin
            case (pc)
                5'd0:    u = '{OP_SUB, L_U,   L_BX, L_BZ};
                5'd1:    u = '{OP_ADD, L_V,   L_AX, L_AZ};
                5'd2:    u = '{OP_MUL, L_U,   L_U,  L_V};
                5'd3:    u = '{OP_SUB, L_V,   L_AX, L_AZ};
                5'd4:    u = '{OP_ADD, L_W,   L_BX, L_BZ};
                5'd5:    u = '{OP_MUL, L_V,   L_V,  L_W};
                5'd6:    u = '{OP_ADD, L_W,   L_U,  L_V};
                5'd7:    u = '{OP_SUB, L_V,   L_V,  L_U};
                5'd8:    u = '{OP_MUL, L_W,   L_W,  L_W};
                5'd9:    u = '{OP_MUL, L_V,   L_V,  L_V};
                5'd10:   u = '{OP_MUL, L_SX,  L_PZ, L_W};
                5'd11:   u = '{OP_MUL, L_SZ,  L_PX, L_V};
                5'd12:   u = '{OP_ADD, L_U,   L_DX, L_DZ};
                5'd13:   u = '{OP_MUL, L_U,   L_U,  L_U};
                5'd14:   u = '{OP_SUB, L_V,   L_DX, L_DZ};
                5'd15:   u = '{OP_MUL, L_V,   L_V,  L_V};
                5'd16:   u = '{OP_SUB, L_W,   L_U,  L_V};
                5'd17:   u = '{OP_MUL, L_DOX, L_U,  L_V};
                5'd18:   u = '{OP_MUL, L_U,   L_W,  L_A24};
                5'd19:   u = '{OP_ADD, L_U,   L_U,  L_V};
                5'd20:   u = '{OP_MUL, L_DOZ, L_W,  L_U};
                default: u = '{OP_ADD, L_U,   L_U,  L_U};
            endcase
            return u;
        end
    endfunction

endpackage

// ===== rtl/mlx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlx_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mlx_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/mlx_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlx_mul64
// Digit-serial 64x64 multiplier, one 4-bit digit of the multiplier a cycle.
// ----------------------------------------------------------------------------
module mlx_mul64
    import mlx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    output logic [WORD_W-1:0] prod_hi,
    output logic [WORD_W-1:0] prod_lo,
    output logic              done
);

    logic [WORD_W-1:0]       a_reg;
    logic [WORD_W-1:0]       b_reg;
    logic [WORD_W-1:0]       hi_reg;
    logic [WORD_W-1:0]       lo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [WORD_W+DIG_W-1:0] part_next;

    // partial sum of the upper half plus a times one digit
    assign part_next = {{DIG_W{1'b0}}, hi_reg}
                     + ({{DIG_W{1'b0}}, a_reg} * {{WORD_W{1'b0}}, b_reg[DIG_W-1:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NDIG - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= op_a;
            b_reg  <= op_b;
            hi_reg <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= part_next[WORD_W+DIG_W-1:DIG_W];
            lo_reg <= {part_next[DIG_W-1:0], lo_reg[WORD_W-1:DIG_W]};
            b_reg  <= b_reg >> DIG_W;
        end
    end

    assign prod_hi = hi_reg;
    assign prod_lo = lo_reg;
    assign done    = done_reg;

endmodule

// ===== rtl/montgomery_ladder_xz_mod128_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// montgomery_ladder_xz_mod128_unit
// XZ Montgomery ladder, k times (X:Z) modulo a 128-bit odd modulus.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item_data) takes one word: point X, Z
//   and scalar k. result channel (result_valid/result_ready/result_data)
//   returns k times the point, one word per item. APB port holds modulus,
//   negated inverse word and (A+2)/4; write it only while the unit is idle.
// Sequence: load and scalar scan, then the first doubling, then one ladder
//   step per scalar bit below the leading one. k = 0 finishes after the
//   load, k = 1 after the scan. Each 128-bit product is built from ten
//   passes of the one 4-bit digit-serial 64x64 multiplier plus accumulate;
//   all eleven products of a step share it, and it sets the rate. An add or
//   subtract goes through the operand read, operand latch, add/subtract and
//   fix states.
// One item is processed at a time; item_ready is high while the sequencer
//   is idle. The result sits in an output register, so the next item is
//   taken while it waits; a stalled receiver holds a finished item only
//   until that register frees up.
// Reset: asynchronous, active low; loads register reset values, empties
//   the output register.
// ----------------------------------------------------------------------------
module montgomery_ladder_xz_mod128_unit
    import mlx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  in_word_t           item_data,
    output logic               result_valid,
    input  logic               result_ready,
    output out_word_t          result_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready
);

    localparam logic [2:0] LD_LAST  = 3'd4;
    localparam logic [2:0] ACC_LAST = 3'd4;
    localparam logic [3:0] MC_M0    = 4'd4;
    localparam logic [3:0] MC_M1    = 4'd7;
    localparam logic [3:0] MC_LAST  = 4'd9;

    // configuration
    logic [WORD_W-1:0] mod_lo_reg;
    logic [WORD_W-1:0] mod_hi_reg;
    logic [WORD_W-1:0] ninv_reg;
    logic [WORD_W-1:0] a24_lo_reg;
    logic [WORD_W-1:0] a24_hi_reg;
    logic [2:0]        cfg_idx;
    logic              cfg_wr;
    logic [RES_W-1:0]  modn;

    // control
    state_t                 state_reg;
    state_t                 state_next;
    in_word_t               in_reg;
    logic [SCALAR_BITS-1:0] ks_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   kbit_reg;
    logic                   init_reg;
    logic                   zero_reg;
    logic [PC_W-1:0]        pc_reg;
    logic [2:0]             ld_cnt_reg;
    logic [3:0]             mcall_reg;
    logic [2:0]             idx_reg;
    logic                   carry_reg;
    logic                   out_valid_reg;
    out_word_t              out_data_reg;
    uop_t                   uop;
    logic                   out_free;

    // datapath
    logic [RES_W-1:0]  opa_reg;
    logic [RES_W-1:0]  opb_reg;
    logic [RES_W-1:0]  sum_reg;
    logic              sflag_reg;
    logic [WORD_W-1:0] w_reg [5];
    logic [WORD_W-1:0] m_reg;

    // register file and multiplier hookup
    logic              ram_we;
    logic [RF_AW-1:0]  ram_waddr;
    logic [RES_W-1:0]  ram_wdata;
    logic [RF_AW-1:0]  ram_raddr_a;
    logic [RF_AW-1:0]  ram_raddr_b;
    logic [RES_W-1:0]  ram_rdata_a;
    logic [RES_W-1:0]  ram_rdata_b;
    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic [WORD_W-1:0] mul_hi;
    logic [WORD_W-1:0] mul_lo;
    logic              mul_done;

    // accumulate and final correction
    logic [1:0]        acc_pos;
    logic [WORD_W-1:0] acc_add;
    logic [WORD_W:0]   acc_sum;
    logic [RES_W-1:0]  fix_x;
    logic              fix_flag;
    logic [RES_W-1:0]  fix_res;

    function automatic logic [RF_AW-1:0] phys(input lreg_t l, input logic kbit,
                                              input logic init);
        logic [RF_AW-1:0] p;
        begin
            case (l)
                L_PX:    p = P_PX;
                L_PZ:    p = P_PZ;
                L_A24:   p = P_A24;
                L_U:     p = P_U;
                L_V:     p = P_V;
                L_W:     p = P_W;
                L_AX:    p = P_X1;
                L_AZ:    p = P_Z1;
                L_BX:    p = P_X2;
                L_BZ:    p = P_Z2;
                L_DX:    p = init ? P_PX : (kbit ? P_X2 : P_X1);
                L_DZ:    p = init ? P_PZ : (kbit ? P_Z2 : P_Z1);
                L_DOX:   p = (init || kbit) ? P_X2 : P_X1;
                L_DOZ:   p = (init || kbit) ? P_Z2 : P_Z1;
                L_SX:    p = kbit ? P_X1 : P_X2;
                L_SZ:    p = kbit ? P_Z1 : P_Z2;
                default: p = P_U;
            endcase
            return p;
        end
    endfunction

    // word offset at which each partial product lands
    function automatic logic [1:0] call_pos(input logic [3:0] c);
        logic [1:0] p;
        begin
            case (c)
                4'd0, 4'd5:             p = 2'd0;
                4'd1, 4'd2, 4'd6, 4'd8: p = 2'd1;
                default:                p = 2'd2;
            endcase
            return p;
        end
    endfunction

    mlx_ram #(
        .WIDTH (RES_W),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    mlx_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .prod_hi (mul_hi),
        .prod_lo (mul_lo),
        .done    (mul_done)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_idx = paddr[PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign modn    = {mod_hi_reg, mod_lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_lo_reg <= WORD_W'(1);
            mod_hi_reg <= WORD_W'(1);
            ninv_reg   <= '0;
            a24_lo_reg <= '0;
            a24_hi_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MOD_LO: mod_lo_reg <= pwdata;
                REG_MOD_HI: mod_hi_reg <= pwdata;
                REG_NINV:   ninv_reg   <= pwdata;
                REG_A24_LO: a24_lo_reg <= pwdata;
                REG_A24_HI: a24_hi_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MOD_LO: prdata = mod_lo_reg;
            REG_MOD_HI: prdata = mod_hi_reg;
            REG_NINV:   prdata = ninv_reg;
            REG_A24_LO: prdata = a24_lo_reg;
            REG_A24_HI: prdata = a24_hi_reg;
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // shared combinational pieces
    // ------------------------------------------------------------------
    assign uop      = uop_rom(pc_reg);
    assign out_free = !out_valid_reg || result_ready;

    assign acc_pos = call_pos(mcall_reg);
    assign acc_add = (idx_reg == {1'b0, acc_pos}) ? mul_lo :
                     (idx_reg == ({1'b0, acc_pos} + 3'd1)) ? mul_hi : '0;
    assign acc_sum = {1'b0, w_reg[idx_reg]} + {1'b0, acc_add}
                   + {{WORD_W{1'b0}}, carry_reg};

    always_comb
    begin
        case (uop.op)
            OP_SUB:
            begin
                fix_x    = sum_reg;
                fix_flag = sflag_reg;
                fix_res  = fix_flag ? (fix_x + modn) : fix_x;
            end
            OP_ADD:
            begin
                fix_x    = sum_reg;
                fix_flag = sflag_reg || (fix_x >= modn);
                fix_res  = fix_flag ? (fix_x - modn) : fix_x;
            end
            default:
            begin
                fix_x    = {w_reg[3], w_reg[2]};
                fix_flag = (w_reg[4] != '0) || (fix_x >= modn);
                fix_res  = fix_flag ? (fix_x - modn) : fix_x;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (ld_cnt_reg == LD_LAST)
                begin
                    state_next = (ks_reg == '0) ? ST_OUT_RD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ks_reg[SCALAR_BITS-1])
                begin
                    state_next = (pos_reg == '0) ? ST_OUT_RD : ST_OP_RD;
                end
            end
            ST_OP_RD:   state_next = ST_OP_LAT;
            ST_OP_LAT:  state_next = (uop.op == OP_MUL) ? ST_MUL_LD : ST_ADDSUB;
            ST_ADDSUB:  state_next = ST_FIX;
            ST_MUL_LD:  state_next = ST_MUL_RUN;
            ST_MUL_RUN:
            begin
                if (mul_done)
                begin
                    state_next = (mcall_reg == MC_M0 || mcall_reg == MC_M1) ?
                                 ST_MUL_LD : ST_MUL_ACC;
                end
            end
            ST_MUL_ACC:
            begin
                if (idx_reg == ACC_LAST)
                begin
                    state_next = (mcall_reg == MC_LAST) ? ST_FIX : ST_MUL_LD;
                end
            end
            ST_FIX:     state_next = ST_NEXT;
            ST_NEXT:
            begin
                if (pc_reg == PC_LAST && pos_reg == '0)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_OP_RD;
                end
            end
            ST_OUT_RD:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = P_U;
        ram_wdata   = fix_res;
        ram_raddr_a = phys(uop.srca, kbit_reg, init_reg);
        ram_raddr_b = phys(uop.srcb, kbit_reg, init_reg);
        mul_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_LOAD:
            begin
                ram_we = 1'b1;
                case (ld_cnt_reg)
                    3'd0:
                    begin
                        ram_waddr = P_PX;
                        ram_wdata = {in_reg.point_x_high, in_reg.point_x_low};
                    end
                    3'd1:
                    begin
                        ram_waddr = P_PZ;
                        ram_wdata = {in_reg.point_z_high, in_reg.point_z_low};
                    end
                    3'd2:
                    begin
                        ram_waddr = P_X1;
                        ram_wdata = {in_reg.point_x_high, in_reg.point_x_low};
                    end
                    3'd3:
                    begin
                        ram_waddr = P_Z1;
                        ram_wdata = {in_reg.point_z_high, in_reg.point_z_low};
                    end
                    default:
                    begin
                        ram_waddr = P_A24;
                        ram_wdata = {a24_hi_reg, a24_lo_reg};
                    end
                endcase
            end
            ST_MUL_LD:
            begin
                mul_start = 1'b1;
            end
            ST_FIX:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(uop.dst, kbit_reg, init_reg);
            end
            ST_OUT_RD, ST_DONE:
            begin
                ram_raddr_a = P_X1;
                ram_raddr_b = P_Z1;
            end
            default: ;
        endcase
    end

    // multiplier operands for each pass of a 128-bit product
    always_comb
    begin
        case (mcall_reg)
            4'd0:    begin mul_a = opa_reg[WORD_W-1:0];     mul_b = opb_reg[WORD_W-1:0];     end
            4'd1:    begin mul_a = opa_reg[WORD_W-1:0];     mul_b = opb_reg[RES_W-1:WORD_W]; end
            4'd2:    begin mul_a = opa_reg[RES_W-1:WORD_W]; mul_b = opb_reg[WORD_W-1:0];     end
            4'd3:    begin mul_a = opa_reg[RES_W-1:WORD_W]; mul_b = opb_reg[RES_W-1:WORD_W]; end
            4'd4:    begin mul_a = w_reg[0];                mul_b = ninv_reg;                end
            4'd5:    begin mul_a = m_reg;                   mul_b = mod_lo_reg;              end
            4'd6:    begin mul_a = m_reg;                   mul_b = mod_hi_reg;              end
            4'd7:    begin mul_a = w_reg[1];                mul_b = ninv_reg;                end
            4'd8:    begin mul_a = m_reg;                   mul_b = mod_lo_reg;              end
            default: begin mul_a = m_reg;                   mul_b = mod_hi_reg;              end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ld_cnt_reg    <= '0;
            pc_reg        <= '0;
            mcall_reg     <= '0;
            idx_reg       <= '0;
            init_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            kbit_reg      <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    ld_cnt_reg <= '0;
                    zero_reg   <= 1'b0;
                    init_reg   <= 1'b0;
                    pos_reg    <= POS_W'(SCALAR_BITS - 1);
                end
                ST_LOAD:
                begin
                    ld_cnt_reg <= ld_cnt_reg + 3'd1;
                    if (ld_cnt_reg == LD_LAST && ks_reg == '0)
                    begin
                        zero_reg <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (!ks_reg[SCALAR_BITS-1])
                    begin
                        pos_reg <= pos_reg - POS_W'(1);
                    end
                    else
                    begin
                        init_reg <= 1'b1;
                        pc_reg   <= PC_DBL;
                    end
                end
                ST_OP_LAT:
                begin
                    mcall_reg <= '0;
                end
                ST_MUL_RUN:
                begin
                    if (mul_done)
                    begin
                        idx_reg <= {1'b0, acc_pos};
                        if (mcall_reg == MC_M0 || mcall_reg == MC_M1)
                        begin
                            mcall_reg <= mcall_reg + 4'd1;
                        end
                    end
                end
                ST_MUL_ACC:
                begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == ACC_LAST)
                    begin
                        mcall_reg <= mcall_reg + 4'd1;
                    end
                end
                ST_NEXT:
                begin
                    if (pc_reg != PC_LAST)
                    begin
                        pc_reg <= pc_reg + PC_W'(1);
                    end
                    else
                    begin
                        init_reg <= 1'b0;
                        if (pos_reg != '0)
                        begin
                            pos_reg  <= pos_reg - POS_W'(1);
                            kbit_reg <= ks_reg[SCALAR_BITS-2];
                            pc_reg   <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    in_reg <= item_data;
                    ks_reg <= item_data.scalar[SCALAR_BITS-1:0];
                end
            end
            ST_SCAN:
            begin
                if (!ks_reg[SCALAR_BITS-1])
                begin
                    ks_reg <= ks_reg << 1;
                end
            end
            ST_OP_LAT:
            begin
                opa_reg <= ram_rdata_a;
                opb_reg <= ram_rdata_b;
                for (int i = 0; i < 5; i++)
                begin
                    w_reg[i] <= '0;
                end
            end
            ST_ADDSUB:
            begin
                if (uop.op == OP_ADD)
                begin
                    {sflag_reg, sum_reg} <= {1'b0, opa_reg} + {1'b0, opb_reg};
                end
                else
                begin
                    sum_reg   <= opa_reg - opb_reg;
                    sflag_reg <= opa_reg < opb_reg;
                end
            end
            ST_MUL_RUN:
            begin
                // reduction factor passes keep only the low word
                if (mul_done && (mcall_reg == MC_M0 || mcall_reg == MC_M1))
                begin
                    m_reg <= mul_lo;
                end
                carry_reg <= 1'b0;
            end
            ST_MUL_ACC:
            begin
                w_reg[idx_reg] <= acc_sum[WORD_W-1:0];
                carry_reg      <= acc_sum[WORD_W];
            end
            ST_NEXT:
            begin
                if (pc_reg == PC_LAST && pos_reg != '0)
                begin
                    ks_reg <= ks_reg << 1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (zero_reg)
                    begin
                        out_data_reg <= '0;
                    end
                    else
                    begin
                        out_data_reg.result_x_low  <= ram_rdata_a[WORD_W-1:0];
                        out_data_reg.result_x_high <= ram_rdata_a[RES_W-1:WORD_W];
                        out_data_reg.result_z_low  <= ram_rdata_b[WORD_W-1:0];
                        out_data_reg.result_z_high <= ram_rdata_b[RES_W-1:WORD_W];
                    end
                end
            end
            default: ;
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

// ===== tb/montgomery_ladder_xz_mod128_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// montgomery_ladder_xz_mod128_unit_tb
// Checks k times (X:Z) on the XZ ladder unit against an in-bench ladder.
// Several modulus and curve settings are loaded over APB while the unit is idle.
// Each setting gets points and mostly short scalars, the all-ones modulus
// also a few full width ones. Both sides idle at random; the receiver holds
// off once for a long stretch. Every result word is checked field by field.
// ----------------------------------------------------------------------------
module montgomery_ladder_xz_mod128_unit_tb;
    import mlx_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    in_word_t           item_data = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    out_word_t          result_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [WORD_W-1:0]  pwdata = '0;
    logic [WORD_W-1:0]  prdata;
    logic               pready;

    montgomery_ladder_xz_mod128_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // bench copy of the configuration
    logic [RES_W-1:0]  cur_mod = 128'h1_0000_0000_0000_0001;
    logic [WORD_W-1:0] cur_ninv = '0;
    logic [RES_W-1:0]  cur_a24 = '0;

    in_word_t  point_q[$];
    out_word_t ladder_expect_q[$];
    int        mismatch_cnt = 0;
    int        results_seen = 0;
    bit        calm = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------- modular arithmetic ----------------
    function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b);
        logic [RES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[RES_W] || s[RES_W-1:0] >= cur_mod)
            s[RES_W-1:0] = s[RES_W-1:0] - cur_mod;
        return s[RES_W-1:0];
    endfunction

    function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b);
        logic [RES_W-1:0] d;
        d = a - b;
        if (a < b)
            d = d + cur_mod;
        return d;
    endfunction

    function automatic logic [RES_W-1:0] mont_mul(input logic [RES_W-1:0] a,
                                                  input logic [RES_W-1:0] b);
        logic [319:0]      w;
        logic [WORD_W-1:0] m;
        logic [RES_W-1:0]  t;
        w = 320'(a) * 320'(b);
        for (int i = 0; i < 2; i++) begin
            m = w[64*i +: 64] * cur_ninv;
            w = w + ((320'(m) * 320'(cur_mod)) << (64 * i));
        end
        t = w[255:128];
        if (w[319:256] != '0 || t >= cur_mod)
            t = t - cur_mod;
        return t;
    endfunction

    function automatic void xz_dbl(input logic [RES_W-1:0] x, input logic [RES_W-1:0] z,
                                   output logic [RES_W-1:0] xo,
                                   output logic [RES_W-1:0] zo);
        logic [RES_W-1:0] u, v, w;
        u = mont_mul(mod_add(x, z), mod_add(x, z));
        v = mont_mul(mod_sub(x, z), mod_sub(x, z));
        w = mod_sub(u, v);
        xo = mont_mul(u, v);
        u = mod_add(mont_mul(w, cur_a24), v);
        zo = mont_mul(w, u);
    endfunction

    function automatic void xz_diff_add(input logic [RES_W-1:0] xa,
                                        input logic [RES_W-1:0] za,
                                        input logic [RES_W-1:0] xb,
                                        input logic [RES_W-1:0] zb,
                                        input logic [RES_W-1:0] xd,
                                        input logic [RES_W-1:0] zd,
                                        output logic [RES_W-1:0] xo,
                                        output logic [RES_W-1:0] zo);
        logic [RES_W-1:0] u, v, w;
        u = mont_mul(mod_sub(xb, zb), mod_add(xa, za));
        v = mont_mul(mod_sub(xa, za), mod_add(xb, zb));
        w = mod_add(u, v);
        v = mod_sub(v, u);
        w = mont_mul(w, w);
        v = mont_mul(v, v);
        xo = mont_mul(zd, w);
        zo = mont_mul(xd, v);
    endfunction

    function automatic out_word_t ladder_mult(input in_word_t p);
        logic [RES_W-1:0]  px, pz, x1, z1, x2, z2, tx, tz;
        logic [WORD_W-1:0] k;
        out_word_t         r;
        int                top;
        px = {p.point_x_high, p.point_x_low};
        pz = {p.point_z_high, p.point_z_low};
        k = p.scalar & ({WORD_W{1'b1}} >> (WORD_W - SCALAR_BITS));
        r = '0;
        if (k == '0)
            return r;
        x1 = px;
        z1 = pz;
        if (k > 1) begin
            xz_dbl(px, pz, x2, z2);
            top = 63;
            while (!k[top])
                top--;
            for (int i = top - 1; i >= 0; i--) begin
                if (k[i]) begin
                    xz_diff_add(x1, z1, x2, z2, px, pz, tx, tz);
                    x1 = tx; z1 = tz;
                    xz_dbl(x2, z2, tx, tz);
                    x2 = tx; z2 = tz;
                end else begin
                    xz_diff_add(x1, z1, x2, z2, px, pz, tx, tz);
                    x2 = tx; z2 = tz;
                    xz_dbl(x1, z1, tx, tz);
                    x1 = tx; z1 = tz;
                end
            end
        end
        r.result_x_low  = x1[63:0];
        r.result_x_high = x1[127:64];
        r.result_z_low  = z1[63:0];
        r.result_z_high = z1[127:64];
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk) begin
        bit       take;
        in_word_t nxt;
        if (item_valid && item_ready)
            ladder_expect_q.push_back(ladder_mult(item_data));
        if (!item_valid || item_ready) begin
            take = point_q.size() > 0 && (calm || $urandom_range(99) >= 13);
            if (take) begin
                nxt = point_q.pop_front();
                item_data <= nxt;
            end
            item_valid <= take;
        end
    end

    // ---------------- monitor ----------------
    int hold_left = 0;
    always @(posedge clk) begin
        out_word_t exp_w;
        if (result_valid && result_ready) begin
            results_seen++;
            if (ladder_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word %h", result_data);
            end else begin
                exp_w = ladder_expect_q.pop_front();
                if (exp_w.result_x_low !== result_data.result_x_low
                    || exp_w.result_x_high !== result_data.result_x_high
                    || exp_w.result_z_low !== result_data.result_z_low
                    || exp_w.result_z_high !== result_data.result_z_high) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %h got %h", exp_w, result_data);
                end
            end
            // long hold-off so the unit fills and stalls its input
            if (results_seen == 40)
                hold_left = 40000;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end else begin
            result_ready <= calm || $urandom_range(99) >= 13;
        end
    end

    // ---------------- stimulus ----------------
    task automatic apb_write(input logic [2:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MOD_LO: cur_mod[63:0]   = val;
            REG_MOD_HI: cur_mod[127:64] = val;
            REG_NINV:   cur_ninv        = val;
            REG_A24_LO: cur_a24[63:0]   = val;
            REG_A24_HI: cur_a24[127:64] = val;
            default: ;
        endcase
    endtask

    function automatic logic [WORD_W-1:0] neg_inverse(input logic [WORD_W-1:0] nl);
        logic [WORD_W-1:0] x;
        x = nl;
        for (int i = 0; i < 6; i++)
            x = x * (64'd2 - nl * x);
        return -x;
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [RES_W-1:0] rand_coord();
        logic [RES_W-1:0] r;
        r = {rand64(), rand64()};
        case ($urandom_range(9))
            0: r = '0;
            1: r = cur_mod - 1;
            2: r = '1;
            3, 4: ;
            default: r = r % cur_mod;
        endcase
        return r;
    endfunction

    task automatic set_curve(input logic [RES_W-1:0] n, input logic [WORD_W-1:0] ninv,
                             input logic [RES_W-1:0] a24);
        apb_write(REG_MOD_LO, n[63:0]);
        apb_write(REG_MOD_HI, n[127:64]);
        apb_write(REG_NINV, ninv);
        apb_write(REG_A24_LO, a24[63:0]);
        apb_write(REG_A24_HI, a24[127:64]);
    endtask

    task automatic push_point(input logic [RES_W-1:0] x, input logic [RES_W-1:0] z,
                              input logic [WORD_W-1:0] k);
        in_word_t p;
        p.point_x_low  = x[63:0];
        p.point_x_high = x[127:64];
        p.point_z_low  = z[63:0];
        p.point_z_high = z[127:64];
        p.scalar       = k;
        point_q.push_back(p);
    endtask

    task automatic add_random(input int count);
        logic [WORD_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(19))
                0:       k = 64'd0;
                1:       k = 64'd1;
                2:       k = 64'($urandom_range(255));
                default: k = 64'($urandom_range(15, 2));
            endcase
            push_point(rand_coord(), rand_coord(), k);
        end
    endtask

    task automatic drain();
        while (point_q.size() > 0 || item_valid || ladder_expect_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial begin
        logic [RES_W-1:0] n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers, no writes yet
        push_point('0, '0, 64'd0);
        push_point('1, '1, 64'd1);
        push_point('1, '1, 64'd2);
        push_point(128'd9, 128'd1, 64'd3);
        add_random(40);
        drain();

        // largest odd modulus with a true inverse
        n = '1;
        set_curve(n, neg_inverse(n[63:0]), {rand64(), rand64()} % n);
        push_point(128'd5, 128'd1, 64'd0);
        push_point(128'd5, 128'd1, 64'd1);
        push_point(n - 1, n - 1, 64'd2);
        push_point('0, '1, 64'd3);
        push_point(128'd5, 128'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        push_point(rand_coord(), rand_coord(), 64'h8000_0000_0000_0000);
        push_point(rand_coord(), rand_coord(), 64'h5555_5555_5555_5555);
        calm = 1'b1;
        add_random(30);
        drain();
        calm = 1'b0;

        // random odd modulus
        n = {rand64() | 64'h1, rand64() | 64'h1};
        set_curve(n, neg_inverse(n[63:0]), {rand64(), rand64()} % n);
        push_point(n - 1, 128'd1, 64'd4);
        add_random(120);
        drain();

        // smallest modulus the high word allows
        n = {64'd1, 64'd1};
        set_curve(n, neg_inverse(64'd1), '1);
        push_point(rand_coord(), rand_coord(), 64'd7);
        add_random(120);
        drain();

        // even modulus, wrong inverse, extreme curve constant
        n = {rand64() | 64'h1, rand64() & ~64'h1};
        set_curve(n, rand64(), '0);
        push_point('1, '0, 64'd6);
        add_random(120);
        drain();

        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
